### rtl/sem_pkg.sv
// Shared types and constants for the Sobel RGB gradient magnitude block.
// No dependencies.
package sem_pkg;
	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [10:0] centre_row;
		logic [10:0] centre_col;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic        frame_last;
	} pix_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GAP,
		ST_SQRT,
		ST_HOLD
	} sem_state_t;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic sqrt_done;
	} sem_cmd_t;

	typedef struct packed {
		logic has_result;
		logic sqrt_last;
	} sem_status_t;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;
	localparam int SQRT_STEPS = 8;
endpackage

### rtl/sem_ctrl.sv
// Controller state machine for the Sobel block.
// Depends on sem_pkg.
module sem_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  sem_pkg::sem_status_t  status,
	output sem_pkg::sem_cmd_t     cmd
);
	import sem_pkg::*;

	sem_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = status.has_result ? ST_SQRT : ST_GAP;
				end
			end
			// line store read registers refill for the new column
			ST_GAP: begin
				state_d = ST_IDLE;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (status.sqrt_last) begin
					cmd.sqrt_done = 1'b1;
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					in_stall = 1'b0;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d = status.has_result ? ST_SQRT : ST_GAP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### rtl/sem_datapath.sv
// Datapath: line stores, 3x3 window, gradients and bit-serial square roots.
// Depends on sem_pkg.
module sem_datapath #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sem_pkg::pix_in_t      pix_in,
	output sem_pkg::pix_out_t     pix_out,
	input  logic                  cfg_we,
	input  logic                  cfg_sel,
	input  logic [11:0]           cfg_data,
	output logic [11:0]           width_q,
	output logic [11:0]           height_q,
	input  sem_pkg::sem_cmd_t     cmd,
	output sem_pkg::sem_status_t  status
);
	import sem_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [23:0] upper_mem [MAX_WIDTH];
	logic [23:0] middle_mem [MAX_WIDTH];
	logic [23:0] win_q [9];
	logic [10:0] col_q, row_q;
	logic [2:0]  step_q;
	logic [16:0] rem_q [3];
	logic [7:0]  root_q [3];
	logic [15:0] sq_q [3];
	logic        sat_q [3];
	logic [10:0] out_row_q, out_col_q;
	logic        out_last_q;
	logic [10:0] res_row_q, res_col_q;
	logic        res_last_q;
	logic [23:0] top_q, mid_q;

	logic [AW-1:0] addr;
	logic [23:0] px;
	logic [11:0] cnext;
	logic [11:0] rnext;

	function automatic logic [11:0] clampv(input logic [11:0] v, input int mx);
		logic [11:0] m;
		m = 12'(mx > 4095 ? 4095 : mx);
		if (v < 12'd3) return 12'd3;
		if (v > m) return m;
		return v;
	endfunction

	assign px = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
	assign addr = (32'(col_q) >= MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : AW'(col_q);
	assign cnext = {1'b0, col_q} + 12'd1;
	assign rnext = {1'b0, row_q} + 12'd1;
	assign status.has_result = (row_q >= 11'd2) && (col_q >= 11'd2);
	assign status.sqrt_last = (step_q == 3'(SQRT_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			upper_mem[addr]  <= mid_q;
			middle_mem[addr] <= px;
		end
		top_q <= upper_mem[addr];
		mid_q <= middle_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
			col_q <= '0;
			row_q <= '0;
			width_q <= 12'd640;
			height_q <= 12'd480;
		end else if (cfg_we) begin
			if (cfg_sel == REG_WIDTH) width_q <= clampv(cfg_data, MAX_WIDTH);
			else height_q <= clampv(cfg_data, MAX_HEIGHT);
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
			end
			win_q[2] <= top_q;
			win_q[5] <= mid_q;
			win_q[8] <= px;
			if (cnext >= width_q) begin
				col_q <= '0;
				row_q <= (rnext >= height_q) ? '0 : rnext[10:0];
			end else begin
				col_q <= cnext[10:0];
			end
		end
	end

	// gradient and square sums, computed from the window after load
	logic [16:0] sum_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [11:0] p [9];
			logic signed [11:0] gx, gy;
			logic [21:0] s;
			for (int i = 0; i < 9; i++) p[i] = 12'(win_q[i][23-8*k -: 8]);
			gx = (p[0] + 12'(p[3] <<< 1) + p[6]) - (p[2] + 12'(p[5] <<< 1) + p[8]);
			gy = (p[0] + 12'(p[1] <<< 1) + p[2]) - (p[6] + 12'(p[7] <<< 1) + p[8]);
			s = 22'(gx) * 22'(gx) + 22'(gy) * 22'(gy);
			sum_c[k] = (s >= 22'd65536) ? 17'h10000 : 17'(s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= '0;
		else if (cmd.sqrt_step) step_q <= status.sqrt_last ? '0 : step_q + 3'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_row_q <= row_q - 11'd1;
			res_col_q <= col_q - 11'd1;
			res_last_q <= ({1'b0, row_q} == height_q - 12'd1) &&
				({1'b0, col_q} == width_q - 12'd1);
		end
		if (cmd.sqrt_step) begin
			for (int k = 0; k < 3; k++) begin
				logic [15:0] v;
				logic [7:0]  r;
				logic [9:0]  tr;
				logic [17:0] rem;
				if (step_q == 3'd0) begin
					v = sum_c[k][15:0];
					sat_q[k] <= sum_c[k][16];
					r = '0;
					rem = '0;
				end else begin
					v = sq_q[k];
					r = root_q[k];
					rem = {1'b0, rem_q[k]};
				end
				rem = {rem[15:0], v[15:14]};
				tr = {r, 2'b01};
				if (rem >= 18'(tr)) begin
					rem = rem - 18'(tr);
					r = {r[6:0], 1'b1};
				end else begin
					r = {r[6:0], 1'b0};
				end
				rem_q[k] <= rem[16:0];
				root_q[k] <= r;
				sq_q[k] <= {v[13:0], 2'b00};
			end
		end
		if (cmd.sqrt_done) begin
			out_row_q <= res_row_q;
			out_col_q <= res_col_q;
			out_last_q <= res_last_q;
		end
	end

	always_comb begin
		pix_out.centre_row = out_row_q;
		pix_out.centre_col = out_col_q;
		pix_out.frame_last = out_last_q;
		pix_out.red_out   = sat_q[0] ? 8'hFF : root_q[0];
		pix_out.green_out = sat_q[1] ? 8'hFF : root_q[1];
		pix_out.blue_out  = sat_q[2] ? 8'hFF : root_q[2];
	end
endmodule

### rtl/sobel_edge_magnitude_rgb.sv
// Top level of the Sobel RGB gradient magnitude block.
// Depends on sem_pkg, sem_ctrl, sem_datapath.
// Border pixels: the accept, then a gap state while the line store reads refill.
// Interior pixels: the accept, then the 8-step bit-serial square root, then the result is
// held; no new pixel is taken until the result leaves. A stalled result stalls the input.
// Reset clears window, counters, FSM and sets width 640, height 480; line stores
// are not cleared.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sem_pkg::pix_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sem_pkg::pix_out_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import sem_pkg::*;

	sem_cmd_t    cmd;
	sem_status_t status;
	logic [11:0] width_q, height_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2:0] == 3'd0) ? {20'd0, width_q} :
		(paddr[2:0] == 3'd4) ? {20'd0, height_q} : 32'd0;

	sem_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	sem_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .pix_in(in_data), .pix_out(out_data),
		.cfg_we(cfg_we), .cfg_sel(paddr[2]), .cfg_data(pwdata[11:0]),
		.width_q(width_q), .height_q(height_q), .cmd(cmd), .status(status)
	);
endmodule

### rtl/sem_checker.sv
// Port-level checker for the Sobel block, bound to the top level.
// Depends on sem_pkg.
module sem_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input sem_pkg::pix_out_t out_data
);
	import sem_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");
	a_no_in_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result waits");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.centre_row != 11'd0 && out_data.centre_col != 11'd0)
		else $error("border centre reported");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
